// ===== rtl/spq_pkg.sv =====
`default_nettype none

package spq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int VALUE_W      = 32;
    localparam int PRIO_W       = 8;
    localparam int STATUS_W     = 2;
    localparam int FILL_W       = 5;

    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    typedef struct packed {
        logic                      valid;
        logic signed [VALUE_W-1:0] value;
        logic [PRIO_W-1:0]         prio;
    } entry_t;

    typedef struct packed {
        logic                      ins;
        logic                      rem;
        logic signed [VALUE_W-1:0] value;
        logic [PRIO_W-1:0]         prio;
    } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/spq_cell.sv =====
`default_nettype none

module spq_cell (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire spq_pkg::cmd_t   cmd,
    input  wire spq_pkg::entry_t left_entry,
    input  wire logic            left_stay,
    input  wire spq_pkg::entry_t right_entry,
    output spq_pkg::entry_t      entry,
    output logic                 stay
);
    import spq_pkg::*;

    logic                      valid_reg, valid_next;
    logic signed [VALUE_W-1:0] value_reg, value_next;
    logic [PRIO_W-1:0]         prio_reg, prio_next;

    // entry holds its place on insert when it sorts at or before the new one
    assign stay = valid_reg && (prio_reg <= cmd.prio);

    always_comb begin
        valid_next = valid_reg;
        value_next = value_reg;
        prio_next  = prio_reg;
        if (cmd.ins) begin
            valid_next = valid_reg || left_stay || left_entry.valid;
            if (!stay) begin
                if (left_stay) begin
                    value_next = cmd.value;
                    prio_next  = cmd.prio;
                end else begin
                    value_next = left_entry.value;
                    prio_next  = left_entry.prio;
                end
            end
        end else if (cmd.rem) begin
            valid_next = right_entry.valid;
            value_next = right_entry.value;
            prio_next  = right_entry.prio;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        prio_reg  <= prio_next;
    end

    assign entry = '{valid: valid_reg, value: value_reg, prio: prio_reg};

endmodule

`default_nettype wire

// ===== rtl/sorted_priority_queue.sv =====
// sorted priority queue, smallest priority number served first, ties in
// arrival order. held as a row of cells, each with one entry, that
// shift right on insert and left on remove, all cells updating together.
// input beats on the s_ channel: s_tuser is the mode (0 insert, 1 remove),
// s_tdata carries value and priority. every input beat yields exactly
// one output beat on the m_ channel, with status in m_tuser (0 done,
// 1 underflow, 2 overflow) and value, priority and fill count in m_tdata.
// the result beat is registered and presented the cycle after the input
// beat is taken. one beat per cycle while the receiver keeps taking
// results, set by the cell update and the one-entry output register.
// when the receiver stalls, the output register holds its beat and
// s_tready drops until that beat is taken; nothing is lost or repeated.
// reset (aresetn low, synchronous) empties the queue at once and clears
// the output valid; no clearing pass is needed.
// an insert into a full queue is refused, a remove from an empty queue
// returns zero value and priority.
`default_nettype none

module sorted_priority_queue #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // item_value[31:0], item_priority[39:32]
    input  wire logic        s_tuser,   // mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // out_value[31:0], out_priority[39:32],
                                        // fill_count[44:40], zero pad
    output logic [1:0]       m_tuser    // status
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    entry_t cell_entry [CAPACITY];
    logic   cell_stay  [CAPACITY];
    entry_t empty_entry;
    cmd_t   cmd;

    logic accept, full, empty, do_ins, do_rem;

    logic [CNT_W-1:0]          count_reg, count_next;
    logic                      out_valid_reg;
    logic signed [VALUE_W-1:0] out_value_reg, out_value_next;
    logic [PRIO_W-1:0]         out_prio_reg, out_prio_next;
    logic [STATUS_W-1:0]       status_reg, status_next;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign full     = cell_entry[CAPACITY-1].valid;
    assign empty    = !cell_entry[0].valid;
    assign do_ins   = accept && (s_tuser == MODE_INSERT) && !full;
    assign do_rem   = accept && (s_tuser == MODE_REMOVE) && !empty;

    assign empty_entry = '{valid: 1'b0, value: '0, prio: '0};
    assign cmd = '{ins: do_ins, rem: do_rem,
                   value: s_tdata[VALUE_W-1:0],
                   prio: s_tdata[VALUE_W+PRIO_W-1:VALUE_W]};

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        spq_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cmd         (cmd),
            .left_entry  ((i == 0) ? empty_entry : cell_entry[(i == 0) ? 0 : i-1]),
            .left_stay   ((i == 0) ? 1'b1 : cell_stay[(i == 0) ? 0 : i-1]),
            .right_entry ((i == CAPACITY-1) ? empty_entry
                          : cell_entry[(i == CAPACITY-1) ? i : i+1]),
            .entry       (cell_entry[i]),
            .stay        (cell_stay[i])
        );
    end

    always_comb begin
        count_next     = count_reg;
        out_value_next = '0;
        out_prio_next  = '0;
        status_next    = ST_DONE;
        if (s_tuser == MODE_INSERT) begin
            if (full) begin
                status_next = ST_OVERFLOW;
            end else begin
                count_next = count_reg + CNT_W'(1);
            end
        end else begin
            if (empty) begin
                status_next = ST_UNDERFLOW;
            end else begin
                count_next     = count_reg - CNT_W'(1);
                out_value_next = cell_entry[0].value;
                out_prio_next  = cell_entry[0].prio;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_value_reg <= out_value_next;
            out_prio_reg  <= out_prio_next;
            status_reg    <= status_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {3'b000, FILL_W'(count_reg), out_prio_reg, out_value_reg};

endmodule

`default_nettype wire

// ===== test/tb_sorted_priority_queue.sv =====
`timescale 1ns / 1ps

module tb_sorted_priority_queue;

    import spq_pkg::*;

    localparam int CAPACITY     = CAPACITY_DEF;
    localparam int RANDOM_ITEMS = 1326;
    localparam int IDLE_PCT     = 32;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [PRIO_W-1:0]         prio;
        logic [STATUS_W-1:0]       status;
        logic [FILL_W-1:0]         fill;
    } result_t;

    typedef struct packed {
        logic                      mode;
        logic signed [VALUE_W-1:0] value;
        logic [PRIO_W-1:0]         prio;
        logic                      fixed;
        result_t                   want;
    } stim_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;

    logic signed [VALUE_W-1:0] held_value [CAPACITY];
    logic [PRIO_W-1:0]         held_prio  [CAPACITY];
    int                        held_count = 0;

    result_t pending_results [$];
    int      mismatch_count = 0;
    int      sent_count     = 0;
    int      taken_count    = 0;

    // fixed rows: reset, extremes, ties at head and tail, fill to full, overflow
    stim_row_t directed_rows [24] = '{
        '{MODE_REMOVE, 32'h0,        8'd0,   1'b1, '{32'h0, 8'd0, ST_UNDERFLOW, 5'd0}},
        '{MODE_INSERT, 32'h7fffffff, 8'd255, 1'b1, '{32'h0, 8'd0, ST_DONE, 5'd1}},
        '{MODE_INSERT, 32'h80000000, 8'd0,   1'b1, '{32'h0, 8'd0, ST_DONE, 5'd2}},
        '{MODE_INSERT, 32'h0,        8'd255, 1'b1, '{32'h0, 8'd0, ST_DONE, 5'd3}},
        '{MODE_INSERT, 32'hffffffff, 8'd0,   1'b1, '{32'h0, 8'd0, ST_DONE, 5'd4}},
        '{MODE_INSERT, 32'h55555555, 8'h55,  1'b1, '{32'h0, 8'd0, ST_DONE, 5'd5}},
        '{MODE_INSERT, 32'haaaaaaaa, 8'haa,  1'b1, '{32'h0, 8'd0, ST_DONE, 5'd6}},
        '{MODE_INSERT, 32'h1,        8'd128, 1'b1, '{32'h0, 8'd0, ST_DONE, 5'd7}},
        '{MODE_INSERT, 32'h2,        8'd127, 1'b1, '{32'h0, 8'd0, ST_DONE, 5'd8}},
        '{MODE_INSERT, 32'h3,        8'd128, 1'b1, '{32'h0, 8'd0, ST_DONE, 5'd9}},
        '{MODE_INSERT, 32'h4,        8'd1,   1'b1, '{32'h0, 8'd0, ST_DONE, 5'd10}},
        '{MODE_INSERT, 32'h5,        8'd254, 1'b1, '{32'h0, 8'd0, ST_DONE, 5'd11}},
        '{MODE_INSERT, 32'h6,        8'd0,   1'b1, '{32'h0, 8'd0, ST_DONE, 5'd12}},
        '{MODE_INSERT, 32'h7,        8'd255, 1'b1, '{32'h0, 8'd0, ST_DONE, 5'd13}},
        '{MODE_INSERT, 32'h8,        8'd64,  1'b1, '{32'h0, 8'd0, ST_DONE, 5'd14}},
        '{MODE_INSERT, 32'h9,        8'd64,  1'b1, '{32'h0, 8'd0, ST_DONE, 5'd15}},
        '{MODE_INSERT, 32'ha,        8'd0,   1'b1, '{32'h0, 8'd0, ST_DONE, 5'd16}},
        '{MODE_INSERT, 32'hb,        8'd0,   1'b1, '{32'h0, 8'd0, ST_OVERFLOW, 5'd16}},
        '{MODE_REMOVE, 32'h0,        8'd0,   1'b0, '0},
        '{MODE_REMOVE, 32'h0,        8'd0,   1'b0, '0},
        '{MODE_INSERT, 32'hc,        8'd0,   1'b0, '0},
        '{MODE_REMOVE, 32'h0,        8'd0,   1'b0, '0},
        '{MODE_REMOVE, 32'hffffffff, 8'd255, 1'b0, '0},
        '{MODE_REMOVE, 32'h12345678, 8'd77,  1'b0, '0}
    };

    sorted_priority_queue #(
        .CAPACITY(CAPACITY)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic result_t queue_step(input logic mode,
                                           input logic signed [VALUE_W-1:0] value,
                                           input logic [PRIO_W-1:0] prio);
        result_t r;
        int      pos;
        int      i;
        r        = '0;
        r.status = ST_DONE;
        if (mode == MODE_INSERT) begin
            if (held_count >= CAPACITY) begin
                r.status = ST_OVERFLOW;
            end else begin
                pos = 0;
                while (pos < held_count && held_prio[pos] <= prio)
                    pos++;
                for (i = held_count; i > pos; i--) begin
                    held_value[i] = held_value[i-1];
                    held_prio[i]  = held_prio[i-1];
                end
                held_value[pos] = value;
                held_prio[pos]  = prio;
                held_count++;
            end
        end else if (held_count == 0) begin
            r.status = ST_UNDERFLOW;
        end else begin
            r.value = held_value[0];
            r.prio  = held_prio[0];
            for (i = 0; i + 1 < held_count; i++) begin
                held_value[i] = held_value[i+1];
                held_prio[i]  = held_prio[i+1];
            end
            held_count--;
        end
        r.fill = held_count[FILL_W-1:0];
        return r;
    endfunction

    task automatic note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t mismatch: %s", $time, what);
    endtask

    task automatic send_beat(input logic mode, input logic signed [VALUE_W-1:0] value,
                             input logic [PRIO_W-1:0] prio, input logic fixed,
                             input result_t want);
        result_t predicted;
        // no idling on the sender between beats 700 and 900
        if (sent_count < 700 || sent_count >= 900) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {prio, value};
        do @(posedge aclk); while (!s_tready);
        predicted = queue_step(mode, value, prio);
        pending_results.push_back(fixed ? want : predicted);
        sent_count++;
    endtask

    initial begin
        int                        i;
        int                        k;
        int                        insert_pct;
        logic                      mode;
        logic signed [VALUE_W-1:0] value;
        logic [PRIO_W-1:0]         prio;
        insert_pct = 50;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (directed_rows[r])
            send_beat(directed_rows[r].mode, directed_rows[r].value, directed_rows[r].prio,
                      directed_rows[r].fixed, directed_rows[r].want);
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            // phases lean toward full, balanced or empty
            if (i % 40 == 0) begin
                case ($urandom_range(2))
                    0: insert_pct = 15;
                    1: insert_pct = 50;
                    default: insert_pct = 85;
                endcase
            end
            mode = ($urandom_range(99) < insert_pct) ? MODE_INSERT : MODE_REMOVE;
            if ($urandom_range(9) == 0) begin
                case ($urandom_range(3))
                    0: value = 32'h7fffffff;
                    1: value = 32'h80000000;
                    2: value = 32'h0;
                    default: value = 32'hffffffff;
                endcase
            end else begin
                value = $urandom;
            end
            k = $urandom_range(99);
            if (k < 50)
                prio = PRIO_W'($urandom_range(7));
            else if (k < 85)
                prio = PRIO_W'($urandom_range(255));
            else
                prio = $urandom_range(1) ? 8'd255 : 8'd0;
            // drain pause
            if (sent_count == 500) begin
                s_tvalid <= 1'b0;
                do @(posedge aclk); while (pending_results.size() != 0);
            end
            send_beat(mode, value, prio, 1'b0, '0);
        end
        s_tvalid <= 1'b0;
        for (k = 0; k < 4000 && pending_results.size() != 0; k++)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (pending_results.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        if (mismatch_count == 0)
            $display("[sorted_priority_queue] OK");
        else
            $display("[sorted_priority_queue] ERROR");
        $finish;
    end

    initial begin
        result_t got;
        result_t want;
        logic    rdy;
        int      hold_left;
        logic    hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got = {m_tdata[31:0], m_tdata[39:32], m_tuser, m_tdata[44:40]};
                if (pending_results.size() == 0) begin
                    note_mismatch("result beat with nothing expected");
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want)
                        note_mismatch($sformatf(
                            "want value %0d prio %0d status %0d fill %0d, got %0d %0d %0d %0d",
                            want.value, want.prio, want.status, want.fill,
                            got.value, got.prio, got.status, got.fill));
                end
                taken_count++;
            end
            // long receiver hold so the queue backs up into s_tready
            if (taken_count == 300 && !hold_done) begin
                hold_left = 80;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                rdy = 1'b0;
                hold_left--;
            end else if (taken_count >= 700 && taken_count < 900) begin
                rdy = 1'b1;
            end else begin
                rdy = ($urandom_range(99) >= IDLE_PCT);
            end
            m_tready <= rdy;
        end
    end

    initial begin
        #2000000;
        $display("[sorted_priority_queue] ERROR");
        $finish;
    end

endmodule
